// File: hw/rtl/edc_pkg.sv
// Package for the epoch-seconds to calendar date unit.
// Holds the sequencer state type, time constants and the month length table.
// No dependencies.
`default_nettype none

package edc_pkg;

    // Width of the shared compare-and-subtract unit
    localparam int unsigned SUB_W = 18;

    localparam logic [SUB_W-1:0] SEC_PER_DAY  = 18'd86400;
    localparam logic [SUB_W-1:0] SEC_PER_HOUR = 18'd3600;
    localparam logic [SUB_W-1:0] SEC_PER_MIN  = 18'd60;
    localparam logic [SUB_W-1:0] DAYS_YEAR    = 18'd365;
    localparam logic [SUB_W-1:0] DAYS_LEAP    = 18'd366;

    localparam logic [11:0] FIRST_YEAR   = 12'd1970;
    // Residues of the first year, for the leap rule
    localparam logic [1:0]  FIRST_MOD4   = 2'd2;
    localparam logic [6:0]  FIRST_MOD100 = 7'd70;
    localparam logic [8:0]  FIRST_MOD400 = 9'd370;

    localparam logic [3:0] MONTH_JAN = 4'd0;
    localparam logic [3:0] MONTH_FEB = 4'd1;
    localparam logic [3:0] MONTH_DEC = 4'd11;

    // Bit steps of each long division
    localparam logic [4:0] DAY_STEPS_LAST = 5'd31;
    localparam logic [4:0] HOUR_MSB       = 5'd4;
    localparam logic [4:0] MIN_MSB        = 5'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DAY,
        ST_YEAR,
        ST_MONTH,
        ST_HOUR,
        ST_MIN,
        ST_DONE
    } state_t;

    // Length of a month (index 0 = January), February follows the leap flag
    function automatic logic [SUB_W-1:0] month_days(input logic [3:0] idx, input logic leap);
        logic [SUB_W-1:0] len;
        begin
            case (idx)
                MONTH_FEB: len = leap ? 18'd29 : 18'd28;
                4'd3,
                4'd5,
                4'd8,
                4'd10:     len = 18'd30;
                default:   len = 18'd31;
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/epoch_seconds_to_calendar_date_unit.sv
// From accept to out_valid the unit runs the day division (ST_DAY), takes off whole years (ST_YEAR),
// then whole months (ST_MONTH), divides out hours and minutes (ST_HOUR, ST_MIN) and holds the result
// (ST_DONE); the next word is taken only after the result is held, one word in flight.
// The single 18-bit compare-and-subtract unit serves every step.
// Reset (rst_n, asynchronous, active low) returns the sequencer to idle and drops out_valid.
// Depends on edc_pkg.
`default_nettype none

module epoch_seconds_to_calendar_date_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] epoch_seconds,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [11:0]      year,
    output logic [3:0]       month,
    output logic [4:0]       day_of_month,
    output logic [4:0]       hour,
    output logic [5:0]       minute,
    output logic [5:0]       second
);
    import edc_pkg::*;

    // Sequencer
    state_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;

    // Working registers.
    // num_reg: dividend shifting out at the top while the day count shifts in at
    // the bottom; afterwards its low half holds the remaining day count.
    logic [31:0] num_reg, num_next;
    // rem_reg: remainder of the day division, i.e. seconds of the day
    logic [16:0] rem_reg, rem_next;
    logic [11:0] year_reg, year_next;
    logic [1:0]  mod4_reg, mod4_next;
    logic [6:0]  mod100_reg, mod100_next;
    logic [8:0]  mod400_reg, mod400_next;
    logic [3:0]  mon_reg, mon_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  min_reg, min_next;

    // Output word register
    logic        out_valid_reg, out_valid_next;
    logic [11:0] year_out_reg, year_out_next;
    logic [3:0]  month_out_reg, month_out_next;
    logic [4:0]  day_out_reg, day_out_next;
    logic [4:0]  hour_out_reg, hour_out_next;
    logic [5:0]  min_out_reg, min_out_next;
    logic [5:0]  sec_out_reg, sec_out_next;

    // Shared compare-and-subtract unit
    logic [SUB_W-1:0] sub_a;
    logic [SUB_W-1:0] sub_b;
    logic [SUB_W:0]   sub_diff;
    logic             sub_ok;
    logic             leap;
    logic             accept;
    logic             retire;

    assign leap     = (mod4_reg == 2'd0) && ((mod100_reg != 7'd0) || (mod400_reg == 9'd0));
    assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    // No borrow means a >= b: take the difference
    assign sub_ok   = ~sub_diff[SUB_W];

    assign accept = in_valid && in_ready;
    // The finished word moves to the output register once that register is free
    assign retire = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // Operand selection for the shared unit
    always_comb
    begin
        sub_a = '0;
        sub_b = '0;
        unique case (state_reg)
            ST_DAY:
            begin
                // Restoring division step by seconds per day
                sub_a = {rem_reg, num_reg[31]};
                sub_b = SEC_PER_DAY;
            end
            ST_YEAR:
            begin
                sub_a = {2'b00, num_reg[15:0]};
                sub_b = leap ? DAYS_LEAP : DAYS_YEAR;
            end
            ST_MONTH:
            begin
                sub_a = {2'b00, num_reg[15:0]};
                sub_b = month_days(mon_reg, leap);
            end
            ST_HOUR:
            begin
                sub_a = {1'b0, rem_reg};
                sub_b = SEC_PER_HOUR << cnt_reg[2:0];
            end
            ST_MIN:
            begin
                sub_a = {1'b0, rem_reg};
                sub_b = SEC_PER_MIN << cnt_reg[2:0];
            end
            default:
            begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DAY;
                end
            end
            ST_DAY:
            begin
                if (cnt_reg == DAY_STEPS_LAST)
                begin
                    state_next = ST_YEAR;
                end
            end
            ST_YEAR:
            begin
                if (!sub_ok)
                begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:
            begin
                if (mon_reg == MONTH_DEC || !sub_ok)
                begin
                    state_next = ST_HOUR;
                end
            end
            ST_HOUR:
            begin
                if (cnt_reg == 5'd0)
                begin
                    state_next = ST_MIN;
                end
            end
            ST_MIN:
            begin
                if (cnt_reg == 5'd0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (retire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        cnt_next       = cnt_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        year_next      = year_reg;
        mod4_next      = mod4_reg;
        mod100_next    = mod100_reg;
        mod400_next    = mod400_reg;
        mon_next       = mon_reg;
        hour_next      = hour_reg;
        min_next       = min_reg;
        out_valid_next = out_valid_reg;
        year_out_next  = year_out_reg;
        month_out_next = month_out_reg;
        day_out_next   = day_out_reg;
        hour_out_next  = hour_out_reg;
        min_out_next   = min_out_reg;
        sec_out_next   = sec_out_reg;

        // Drop the held word once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    num_next    = epoch_seconds;
                    rem_next    = '0;
                    cnt_next    = '0;
                    year_next   = FIRST_YEAR;
                    mod4_next   = FIRST_MOD4;
                    mod100_next = FIRST_MOD100;
                    mod400_next = FIRST_MOD400;
                end
            end
            ST_DAY:
            begin
                rem_next = sub_ok ? sub_diff[16:0] : sub_a[16:0];
                num_next = {num_reg[30:0], sub_ok};
                cnt_next = cnt_reg + 5'd1;
            end
            ST_YEAR:
            begin
                // Take off whole years while the days left cover this year
                if (sub_ok)
                begin
                    num_next    = {16'd0, sub_diff[15:0]};
                    year_next   = year_reg + 12'd1;
                    mod4_next   = mod4_reg + 2'd1;
                    mod100_next = (mod100_reg == 7'd99) ? 7'd0 : mod100_reg + 7'd1;
                    mod400_next = (mod400_reg == 9'd399) ? 9'd0 : mod400_reg + 9'd1;
                end
                else
                begin
                    mon_next = MONTH_JAN;
                end
            end
            ST_MONTH:
            begin
                if (mon_reg != MONTH_DEC && sub_ok)
                begin
                    num_next = {16'd0, sub_diff[15:0]};
                    mon_next = mon_reg + 4'd1;
                end
                if (mon_reg == MONTH_DEC || !sub_ok)
                begin
                    cnt_next = HOUR_MSB;
                end
            end
            ST_HOUR:
            begin
                if (sub_ok)
                begin
                    rem_next = sub_diff[16:0];
                end
                hour_next = {hour_reg[3:0], sub_ok};
                cnt_next  = (cnt_reg == 5'd0) ? MIN_MSB : cnt_reg - 5'd1;
            end
            ST_MIN:
            begin
                if (sub_ok)
                begin
                    rem_next = sub_diff[16:0];
                end
                min_next = {min_reg[4:0], sub_ok};
                if (cnt_reg != 5'd0)
                begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            ST_DONE:
            begin
                if (retire)
                begin
                    out_valid_next = 1'b1;
                    year_out_next  = year_reg;
                    month_out_next = mon_reg + 4'd1;
                    day_out_next   = num_reg[4:0] + 5'd1;
                    hour_out_next  = hour_reg;
                    min_out_next   = min_reg;
                    sec_out_next   = rem_reg[5:0];
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt_next;
        num_reg       <= num_next;
        rem_reg       <= rem_next;
        year_reg      <= year_next;
        mod4_reg      <= mod4_next;
        mod100_reg    <= mod100_next;
        mod400_reg    <= mod400_next;
        mon_reg       <= mon_next;
        hour_reg      <= hour_next;
        min_reg       <= min_next;
        year_out_reg  <= year_out_next;
        month_out_reg <= month_out_next;
        day_out_reg   <= day_out_next;
        hour_out_reg  <= hour_out_next;
        min_out_reg   <= min_out_next;
        sec_out_reg   <= sec_out_next;
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign year         = year_out_reg;
    assign month        = month_out_reg;
    assign day_of_month = day_out_reg;
    assign hour         = hour_out_reg;
    assign minute       = min_out_reg;
    assign second       = sec_out_reg;

endmodule

`default_nettype wire

// File: hw/rtl/edc_checker.sv
// Port-level checker for the epoch-seconds to calendar date unit.
// Bound to epoch_seconds_to_calendar_date_unit; no package needed.
`default_nettype none

module edc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [11:0] year,
    input wire logic [3:0]  month,
    input wire logic [4:0]  day_of_month,
    input wire logic [4:0]  hour,
    input wire logic [5:0]  minute,
    input wire logic [5:0]  second
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(year) && $stable(month)
            && $stable(day_of_month) && $stable(hour) && $stable(minute) && $stable(second))
        else $error("result word changed while stalled");

    // One word in flight: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a word while busy");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> year >= 12'd1970 && year <= 12'd2106 && month >= 4'd1
            && month <= 4'd12 && day_of_month >= 5'd1)
        else $error("date field out of range");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59)
        else $error("time field out of range");

endmodule

bind epoch_seconds_to_calendar_date_unit edc_checker u_edc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .hour         (hour),
    .minute       (minute),
    .second       (second)
);

`default_nettype wire

// File: dv/epoch_seconds_to_calendar_date_unit_tb.sv
// Self-checking testbench for epoch_seconds_to_calendar_date_unit.
// Holds its own calendar predictor, a queued valid/ready driver and a checking monitor.
// Depends only on the unit under test and its package.
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_date_unit_tb;

    // Time and calendar constants, kept apart from the design's own package
    localparam int unsigned SECS_IN_DAY   = 86400;
    localparam int unsigned SECS_IN_HOUR  = 3600;
    localparam int unsigned SECS_IN_MIN   = 60;
    localparam int unsigned EPOCH_YEAR    = 1970;
    localparam int unsigned LAST_YEAR     = 2106;

    localparam int unsigned RANDOM_WORDS   = 1630;
    localparam int unsigned REPORT_LIMIT   = 10;
    // Worst idle stretch: conversion latency, longest stall, longest gap and the hold-off
    localparam int unsigned WATCHDOG_LIMIT = 6000;
    localparam int unsigned HOLD_OFF_LEN   = 900;
    localparam int unsigned HOLD_OFF_AT    = 300;
    localparam int unsigned DRAIN_CYCLES   = 250;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } date_time_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic [31:0] epoch_seconds = '0;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;

    // Words still to be offered, and calendar dates owed by the unit in order
    logic [31:0] epochs_to_send[$];
    date_time_t  dates_due[$];

    int unsigned words_sent      = 0;
    int unsigned dates_checked   = 0;
    int unsigned fault_count     = 0;
    int unsigned directed_count  = 0;
    int unsigned send_gap        = 0;
    int unsigned recv_stall      = 0;
    int unsigned hold_off        = 0;
    bit          hold_off_done   = 1'b0;
    int unsigned blocked_sends   = 0;
    int unsigned quiet_cycles    = 0;
    int unsigned leap_days_seen  = 0;
    int unsigned leap_year_ends  = 0;
    int unsigned min_year_seen   = LAST_YEAR;
    int unsigned max_year_seen   = 0;

    date_time_t  got_date;
    date_time_t  want_date;

    epoch_seconds_to_calendar_date_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .epoch_seconds(epoch_seconds),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .year         (year),
        .month        (month),
        .day_of_month (day_of_month),
        .hour         (hour),
        .minute       (minute),
        .second       (second)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // ------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------

    // Gregorian rule: every fourth year, but not centuries unless divisible by 400
    function automatic bit is_leap_year(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned days_in_year(input int unsigned y);
        return is_leap_year(y) ? 366 : 365;
    endfunction

    // Month numbered from 1; February follows the leap flag
    function automatic int unsigned days_in_month(input int unsigned m, input bit leap);
        case (m)
            2:           return leap ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    // Whole days from the epoch to the given calendar day
    function automatic int unsigned day_index(input int unsigned y, input int unsigned m,
                                              input int unsigned d);
        int unsigned n;
        n = d - 1;
        for (int unsigned yy = EPOCH_YEAR; yy < y; yy++)
            n += days_in_year(yy);
        for (int unsigned mm = 1; mm < m; mm++)
            n += days_in_month(mm, is_leap_year(y));
        return n;
    endfunction

    // Peel whole years, then whole months, off the day count; the year test uses
    // the length of the current year so that Dec 31 of a leap year stays put
    function automatic date_time_t epoch_to_date(input logic [31:0] secs);
        date_time_t  r;
        int unsigned days;
        int unsigned tod;
        int unsigned yr;
        int unsigned mo;
        days = secs / SECS_IN_DAY;
        tod  = secs % SECS_IN_DAY;
        yr   = EPOCH_YEAR;
        while (days >= days_in_year(yr))
        begin
            days -= days_in_year(yr);
            yr++;
        end
        mo = 1;
        while (mo < 12 && days >= days_in_month(mo, is_leap_year(yr)))
        begin
            days -= days_in_month(mo, is_leap_year(yr));
            mo++;
        end
        r.year   = yr[11:0];
        r.month  = mo[3:0];
        r.mday   = 5'(days + 1);
        r.hour   = 5'(tod / SECS_IN_HOUR);
        r.minute = 6'((tod % SECS_IN_HOUR) / SECS_IN_MIN);
        r.second = 6'(tod % SECS_IN_MIN);
        return r;
    endfunction

    // Mostly short idles, some medium, a few long
    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 250);
    endfunction

    // Random timestamp that lands on or near a calendar boundary
    function automatic logic [31:0] boundary_epoch();
        int unsigned    y;
        int unsigned    m;
        int unsigned    d;
        int unsigned    tod;
        longint unsigned secs;
        y = $urandom_range(EPOCH_YEAR, LAST_YEAR);
        m = $urandom_range(1, 12);
        case ($urandom_range(0, 3))
            0:       d = 1;
            1:       d = days_in_month(m, is_leap_year(y));
            2:       d = (m == 2 && is_leap_year(y)) ? 29 : 28;
            default: d = $urandom_range(1, days_in_month(m, is_leap_year(y)));
        endcase
        case ($urandom_range(0, 4))
            0:       tod = $urandom_range(0, 2);
            1:       tod = SECS_IN_DAY - 1 - $urandom_range(0, 2);
            2:       tod = $urandom_range(0, 23) * SECS_IN_HOUR + $urandom_range(0, 1) * 3599;
            3:       tod = $urandom_range(0, 1439) * SECS_IN_MIN + $urandom_range(0, 1) * 59;
            default: tod = $urandom_range(0, SECS_IN_DAY - 1);
        endcase
        secs = longint'(day_index(y, m, d)) * SECS_IN_DAY + tod;
        // Past the last representable second: fall back to a plain random word
        if (secs > 64'hFFFF_FFFF)
            return $urandom;
        return secs[31:0];
    endfunction

    function automatic bit date_differs(input date_time_t a, input date_time_t b);
        return (a.year != b.year) || (a.month != b.month) || (a.mday != b.mday) ||
               (a.hour != b.hour) || (a.minute != b.minute) || (a.second != b.second);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer one word at a time, hold it until taken, then idle at random.
    // Every fourth block of 150 words runs back to back with no gaps.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap  = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                dates_due.push_back(epoch_to_date(epoch_seconds));
                words_sent++;
            end
            if (in_valid && !in_ready)
                blocked_sends++;
            // Only move on once the current word has gone; never drop valid early
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (epochs_to_send.size() != 0)
                begin
                    in_valid      <= 1'b1;
                    epoch_seconds <= epochs_to_send.pop_front();
                    send_gap       = ((words_sent / 150) % 4 == 3) ? 0 : idle_length();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each word taken against the oldest date owed, then
    // choose the next stall. Once, hold off for a long stretch so the unit
    // fills and has to refuse the driver.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_stall = 0;
            hold_off   = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got_date = '{year, month, day_of_month, hour, minute, second};
                if (dates_due.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("[%0t] unexpected word: %0d-%0d-%0d %0d:%0d:%0d", $realtime,
                                 got_date.year, got_date.month, got_date.mday,
                                 got_date.hour, got_date.minute, got_date.second);
                end
                else
                begin
                    want_date = dates_due.pop_front();
                    if (date_differs(got_date, want_date))
                    begin
                        fault_count++;
                        if (fault_count <= REPORT_LIMIT)
                        begin
                            $write("[%0t] mismatch: expected %0d-%0d-%0d %0d:%0d:%0d",
                                   $realtime, want_date.year, want_date.month,
                                   want_date.mday, want_date.hour, want_date.minute,
                                   want_date.second);
                            $display(", got %0d-%0d-%0d %0d:%0d:%0d",
                                     got_date.year, got_date.month, got_date.mday,
                                     got_date.hour, got_date.minute, got_date.second);
                        end
                    end
                end
                dates_checked++;
                if (got_date.month == 2 && got_date.mday == 29)
                    leap_days_seen++;
                if (got_date.month == 12 && got_date.mday == 31 && is_leap_year(got_date.year))
                    leap_year_ends++;
                if (got_date.year < min_year_seen)
                    min_year_seen = got_date.year;
                if (got_date.year > max_year_seen)
                    max_year_seen = got_date.year;
                recv_stall = ((dates_checked / 150) % 4 == 1) ? 0 : idle_length();
                if (dates_checked == HOLD_OFF_AT && !hold_off_done)
                begin
                    hold_off      = HOLD_OFF_LEN;
                    hold_off_done = 1'b1;
                end
            end
            // Stalls count down whether or not a word is waiting, so they fall on every phase
            if (hold_off > 0)
            begin
                hold_off--;
                out_ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog: end the run if nothing moves on either side for too long
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] watchdog: no handshake for %0d cycles, %0d dates still owed",
                     $realtime, quiet_cycles, dates_due.size());
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned pick;

        // Directed words: range ends, day and hour edges, month and year ends,
        // leap days, Dec 31 of leap years, and the non-leap century 2100
        epochs_to_send.push_back(32'd0);
        epochs_to_send.push_back(32'd59);
        epochs_to_send.push_back(32'd3599);
        epochs_to_send.push_back(32'd3600);
        epochs_to_send.push_back(SECS_IN_DAY - 1);
        epochs_to_send.push_back(SECS_IN_DAY);
        epochs_to_send.push_back(day_index(1970, 1, 31) * SECS_IN_DAY + SECS_IN_DAY - 1);
        epochs_to_send.push_back(day_index(1970, 2, 1) * SECS_IN_DAY);
        epochs_to_send.push_back(day_index(1970, 12, 31) * SECS_IN_DAY + SECS_IN_DAY - 1);
        epochs_to_send.push_back(day_index(1972, 2, 29) * SECS_IN_DAY);
        epochs_to_send.push_back(day_index(1972, 12, 31) * SECS_IN_DAY);
        epochs_to_send.push_back(day_index(1972, 12, 31) * SECS_IN_DAY + SECS_IN_DAY - 1);
        epochs_to_send.push_back(day_index(1973, 1, 1) * SECS_IN_DAY);
        epochs_to_send.push_back(day_index(2000, 2, 29) * SECS_IN_DAY + 43200);
        epochs_to_send.push_back(day_index(2000, 12, 31) * SECS_IN_DAY + SECS_IN_DAY - 1);
        epochs_to_send.push_back(day_index(2100, 2, 28) * SECS_IN_DAY + SECS_IN_DAY - 1);
        epochs_to_send.push_back(day_index(2100, 3, 1) * SECS_IN_DAY);
        epochs_to_send.push_back(day_index(2104, 12, 31) * SECS_IN_DAY + SECS_IN_DAY - 1);
        epochs_to_send.push_back(32'h7FFF_FFFF);
        epochs_to_send.push_back(32'h8000_0000);
        epochs_to_send.push_back(32'h5555_5555);
        epochs_to_send.push_back(32'hAAAA_AAAA);
        epochs_to_send.push_back(32'hFFFF_FFFE);
        epochs_to_send.push_back(32'hFFFF_FFFF);
        directed_count = epochs_to_send.size();

        // Random words: plain 32-bit values, calendar boundaries, and early years
        // where the year loop is short
        repeat (RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                epochs_to_send.push_back($urandom);
            else if (pick < 85)
                epochs_to_send.push_back(boundary_epoch());
            else
                epochs_to_send.push_back($urandom_range(0, 400 * SECS_IN_DAY));
        end

        // Hold reset, then release it away from the rising edge
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every word to be taken, every date to come back, then drain
        while (epochs_to_send.size() != 0 || in_valid)
            @(posedge clk);
        while (dates_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        fault_count += dates_due.size();
        $display("Converted %0d timestamps (%0d directed), %0d dates checked, %0d faults.",
                 words_sent, directed_count, dates_checked, fault_count);
        $display("Years %0d to %0d, %0d leap days, %0d leap-year Dec 31s, %0d refused offers.",
                 min_year_seen, max_year_seen, leap_days_seen, leap_year_ends, blocked_sends);
        if (fault_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
